// ----- sv/rmwq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmwq_pkg: shared types and constants of the recursive mutex unit
// widths, status codes and request kinds
// ----------------------------------------------------------------------------
package rmwq_pkg;
    localparam int MAX_WAITERS = 16;
    localparam int ID_BITS     = 6;
    localparam int DEPTH_BITS  = 16;
    localparam int QPTR_BITS   = $clog2(MAX_WAITERS);
    localparam int QCNT_BITS   = $clog2(MAX_WAITERS + 1);

    localparam logic [1:0] KIND_LOCK    = 2'd0;
    localparam logic [1:0] KIND_TRYLOCK = 2'd1;
    localparam logic [1:0] KIND_UNLOCK  = 2'd2;
    localparam logic [1:0] KIND_CANCEL  = 2'd3;

    localparam logic [3:0] ST_ACQUIRED    = 4'd0;
    localparam logic [3:0] ST_NESTED      = 4'd1;
    localparam logic [3:0] ST_QUEUED      = 4'd2;
    localparam logic [3:0] ST_BUSY        = 4'd3;
    localparam logic [3:0] ST_HELD        = 4'd4;
    localparam logic [3:0] ST_FREED       = 4'd5;
    localparam logic [3:0] ST_HANDED      = 4'd6;
    localparam logic [3:0] ST_CANCELLED   = 4'd7;
    localparam logic [3:0] ST_NOT_WAITING = 4'd8;
    localparam logic [3:0] ST_ERROR       = 4'd9;

    typedef logic [ID_BITS-1:0]    id_t;
    typedef logic [DEPTH_BITS-1:0] depth_t;
    typedef logic [QPTR_BITS-1:0]  qptr_t;
    typedef logic [QCNT_BITS-1:0]  qcnt_t;

    // memory access requests from the sequencer to the waiter store
    typedef struct packed {
        logic  rd_en;
        qptr_t rd_addr;
        logic  wr_en;
        qptr_t wr_addr;
        id_t   wr_data;
    } qmem_req_t;
endpackage

// ----- sv/rmwq_waiter_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmwq_waiter_ram: waiter id store
// one write and one registered read port
// ----------------------------------------------------------------------------
module rmwq_waiter_ram (
    input  logic               aclk,
    input  rmwq_pkg::qmem_req_t req,
    output rmwq_pkg::id_t       rd_data
);
    rmwq_pkg::id_t mem [rmwq_pkg::MAX_WAITERS];

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data <= mem[req.rd_addr];
        end
    end
endmodule

// ----- sv/recursive_mutex_with_wait_queue_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// recursive_mutex_with_wait_queue_unit: hardware mutex with fifo of waiters
// lock, trylock, unlock and cancel-wait requests, one status item each
// ----------------------------------------------------------------------------
// One request item at a time. Lock, trylock and a plain unlock go straight from
// acceptance to the result state; a lock that must check the queue, an unlock
// that hands over and a cancel-wait walk the waiter store one entry at a time
// through its single read port (registered), with a scan and a check state per
// entry; removal moves later entries down via shift and move states. The result
// sits in an output register; the next item is taken once it is free or draining.
// A store entry is read only below the waiter count, so it needs no clearing.
// ----------------------------------------------------------------------------
module recursive_mutex_with_wait_queue_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,        // recursive_enable
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,         // [1:0] kind, [7:2] requester_id
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata          // [3:0] status, [9:4] owner_id,
                                         // [10] owner_present, [26:11] hold_depth
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;  // read issued, waiting data
    localparam logic [2:0] S_CHECK = 3'd2;  // data back, compare
    localparam logic [2:0] S_SHIFT = 3'd3;  // compaction: read next
    localparam logic [2:0] S_MOVE  = 3'd4;  // compaction: write back
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic recen_reg;
    rmwq_pkg::id_t owner_reg, owner_next;
    logic owned_reg, owned_next;
    rmwq_pkg::depth_t depth_reg, depth_next;
    rmwq_pkg::qcnt_t cnt_reg, cnt_next;
    logic [1:0] kind_reg, kind_next;
    rmwq_pkg::id_t id_reg, id_next;
    rmwq_pkg::qcnt_t idx_reg, idx_next;  // scan / compaction pointer
    logic [3:0] st_reg, st_next;
    logic ovalid_reg;
    logic [31:0] odata_reg;
    rmwq_pkg::qmem_req_t req;
    rmwq_pkg::id_t rd_data;
    logic take, out_free;

    rmwq_waiter_ram u_ram (.aclk(aclk), .req(req), .rd_data(rd_data));

    assign out_free  = !ovalid_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE) && out_free;
    assign take      = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = ovalid_reg;
    assign m_tdata   = odata_reg;

    always_comb begin
        state_next = state_reg;
        owner_next = owner_reg;
        owned_next = owned_reg;
        depth_next = depth_reg;
        cnt_next   = cnt_reg;
        kind_next  = kind_reg;
        id_next    = id_reg;
        idx_next   = idx_reg;
        st_next    = st_reg;
        req        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (take) begin
                    kind_next = s_tdata[1:0];
                    id_next   = s_tdata[7:2];
                    idx_next  = '0;
                    state_next = S_DONE;
                    st_next    = rmwq_pkg::ST_ERROR;
                    case (s_tdata[1:0])
                        rmwq_pkg::KIND_LOCK, rmwq_pkg::KIND_TRYLOCK: begin
                            if (!owned_reg) begin
                                owner_next = s_tdata[7:2];
                                owned_next = 1'b1;
                                depth_next = rmwq_pkg::depth_t'(1);
                                st_next    = rmwq_pkg::ST_ACQUIRED;
                            end else if (owner_reg == s_tdata[7:2] && recen_reg) begin
                                if (depth_reg == '1) begin
                                    st_next = rmwq_pkg::ST_ERROR;
                                end else begin
                                    depth_next = depth_reg + 1'b1;
                                    st_next    = rmwq_pkg::ST_NESTED;
                                end
                            end else if (s_tdata[1:0] == rmwq_pkg::KIND_TRYLOCK) begin
                                st_next = rmwq_pkg::ST_BUSY;
                            end else if (owner_reg == s_tdata[7:2] ||
                                         cnt_reg >= rmwq_pkg::QCNT_BITS'(rmwq_pkg::MAX_WAITERS)) begin
                                st_next = rmwq_pkg::ST_ERROR;
                            end else if (cnt_reg == '0) begin
                                req.wr_en   = 1'b1;
                                req.wr_addr = '0;
                                req.wr_data = s_tdata[7:2];
                                cnt_next    = cnt_reg + 1'b1;
                                st_next     = rmwq_pkg::ST_QUEUED;
                            end else begin
                                req.rd_en   = 1'b1;
                                req.rd_addr = '0;
                                state_next  = S_SCAN;
                            end
                        end
                        rmwq_pkg::KIND_UNLOCK: begin
                            if (!owned_reg || depth_reg == '0) begin
                                st_next = rmwq_pkg::ST_ERROR;
                            end else if (depth_reg != rmwq_pkg::depth_t'(1)) begin
                                depth_next = depth_reg - 1'b1;
                                st_next    = rmwq_pkg::ST_HELD;
                            end else if (cnt_reg == '0) begin
                                depth_next = '0;
                                owned_next = 1'b0;
                                owner_next = '0;
                                st_next    = rmwq_pkg::ST_FREED;
                            end else begin
                                req.rd_en   = 1'b1;
                                req.rd_addr = '0;
                                state_next  = S_SCAN;
                            end
                        end
                        default: begin
                            if (cnt_reg == '0) begin
                                st_next = rmwq_pkg::ST_NOT_WAITING;
                            end else begin
                                req.rd_en   = 1'b1;
                                req.rd_addr = '0;
                                state_next  = S_SCAN;
                            end
                        end
                    endcase
                end
            end
            S_SCAN: begin
                state_next = S_CHECK;
            end
            S_CHECK: begin
                // rd_data is entry idx_reg
                if (kind_reg == rmwq_pkg::KIND_UNLOCK) begin
                    owner_next = rd_data;
                    depth_next = rmwq_pkg::depth_t'(1);
                    st_next    = rmwq_pkg::ST_HANDED;
                    state_next = S_SHIFT;
                end else if (rd_data == id_reg) begin
                    if (kind_reg == rmwq_pkg::KIND_LOCK) begin
                        st_next    = rmwq_pkg::ST_ERROR;
                        state_next = S_DONE;
                    end else begin
                        st_next    = rmwq_pkg::ST_CANCELLED;
                        state_next = S_SHIFT;
                    end
                end else if (idx_reg + 1'b1 >= cnt_reg) begin
                    if (kind_reg == rmwq_pkg::KIND_LOCK) begin
                        req.wr_en   = 1'b1;
                        req.wr_addr = rmwq_pkg::qptr_t'(cnt_reg);
                        req.wr_data = id_reg;
                        cnt_next    = cnt_reg + 1'b1;
                        st_next     = rmwq_pkg::ST_QUEUED;
                    end else begin
                        st_next = rmwq_pkg::ST_NOT_WAITING;
                    end
                    state_next = S_DONE;
                end else begin
                    idx_next    = idx_reg + 1'b1;
                    req.rd_en   = 1'b1;
                    req.rd_addr = rmwq_pkg::qptr_t'(idx_reg + 1'b1);
                    state_next  = S_SCAN;
                end
            end
            S_SHIFT: begin
                // remove entry idx_reg by moving later entries down
                if (idx_reg + 1'b1 >= cnt_reg) begin
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = S_DONE;
                end else begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = rmwq_pkg::qptr_t'(idx_reg + 1'b1);
                    state_next  = S_MOVE;
                end
            end
            S_MOVE: begin
                req.wr_en   = 1'b1;
                req.wr_addr = rmwq_pkg::qptr_t'(idx_reg);
                req.wr_data = rd_data;
                idx_next    = idx_reg + 1'b1;
                state_next  = S_SHIFT;
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            recen_reg  <= 1'b0;
            owner_reg  <= '0;
            owned_reg  <= 1'b0;
            depth_reg  <= '0;
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            owner_reg <= owner_next;
            owned_reg <= owned_next;
            depth_reg <= depth_next;
            cnt_reg   <= cnt_next;
            if (cfg_valid && cfg_ready) begin
                recen_reg <= cfg_data;
            end
            if (state_reg == S_DONE && out_free) begin
                ovalid_reg <= 1'b1;
            end else if (m_tready) begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg <= kind_next;
        id_reg   <= id_next;
        idx_reg  <= idx_next;
        st_reg   <= st_next;
        if (state_reg == S_DONE && out_free) begin
            odata_reg <= {5'd0, depth_reg, owned_reg,
                          owned_reg ? owner_reg : rmwq_pkg::id_t'(0), st_reg};
        end
    end

    // queue count never exceeds its capacity
    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= rmwq_pkg::QCNT_BITS'(rmwq_pkg::MAX_WAITERS))
        else $error("waiter count over capacity");
    // a free mutex carries no depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        !owned_reg |-> depth_reg == '0)
        else $error("free mutex with depth");
    // input taken only when idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        take |-> state_reg == S_IDLE)
        else $error("item taken while busy");
    // waiters only exist while the mutex is held
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg != '0) |-> owned_reg)
        else $error("waiters on free mutex");
endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the recursive mutex unit
// drives lock, trylock, unlock and cancel-wait items, predicts each status
// item and checks every field in order, across several recursive settings
// ----------------------------------------------------------------------------

// expected status items and the predicted mutex state
class mutex_scoreboard;
    bit                     recursive;
    rmwq_pkg::id_t          owner;
    bit                     owned;
    rmwq_pkg::depth_t       depth;
    rmwq_pkg::id_t          waiters[$];
    logic [26:0]            pending[$];
    int                     errors;

    function void clear();
        recursive = 0;
        owner = '0;
        owned = 0;
        depth = '0;
        waiters.delete();
        pending.delete();
        errors = 0;
    endfunction

    function int waiter_pos(rmwq_pkg::id_t id);
        foreach (waiters[i])
            if (waiters[i] == id) return i;
        return -1;
    endfunction

    // work out the answer to one accepted request
    function void note_request(logic [1:0] kind, rmwq_pkg::id_t id);
        logic [3:0] st;
        int pos;
        st = rmwq_pkg::ST_ERROR;
        case (kind)
            rmwq_pkg::KIND_LOCK, rmwq_pkg::KIND_TRYLOCK: begin
                if (!owned) begin
                    owner = id; owned = 1; depth = 1; st = rmwq_pkg::ST_ACQUIRED;
                end else if (owner == id && recursive) begin
                    if (depth == '1) st = rmwq_pkg::ST_ERROR;
                    else begin
                        depth++; st = rmwq_pkg::ST_NESTED;
                    end
                end else if (kind == rmwq_pkg::KIND_TRYLOCK) begin
                    st = rmwq_pkg::ST_BUSY;
                end else if (owner == id || waiters.size() >= rmwq_pkg::MAX_WAITERS
                             || waiter_pos(id) >= 0) begin
                    st = rmwq_pkg::ST_ERROR;
                end else begin
                    waiters.push_back(id); st = rmwq_pkg::ST_QUEUED;
                end
            end
            rmwq_pkg::KIND_UNLOCK: begin
                if (!owned || depth == 0) st = rmwq_pkg::ST_ERROR;
                else begin
                    depth--;
                    if (depth != 0) st = rmwq_pkg::ST_HELD;
                    else if (waiters.size() == 0) begin
                        owned = 0; owner = '0; st = rmwq_pkg::ST_FREED;
                    end else begin
                        owner = waiters.pop_front(); depth = 1;
                        st = rmwq_pkg::ST_HANDED;
                    end
                end
            end
            default: begin
                pos = waiter_pos(id);
                if (pos >= 0) begin
                    waiters.delete(pos); st = rmwq_pkg::ST_CANCELLED;
                end else st = rmwq_pkg::ST_NOT_WAITING;
            end
        endcase
        pending.push_back({depth, owned, owned ? owner : rmwq_pkg::id_t'(0), st});
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        errors++;
    endtask

    task check_status(logic [31:0] got);
        logic [26:0] want;
        if (pending.size() == 0) begin
            report("unexpected item", got, 0);
            return;
        end
        want = pending.pop_front();
        if (got[3:0] !== want[3:0])     report("status", got[3:0], want[3:0]);
        if (got[9:4] !== want[9:4])     report("owner_id", got[9:4], want[9:4]);
        if (got[10] !== want[10])       report("owner_present", got[10], want[10]);
        if (got[26:11] !== want[26:11]) report("hold_depth", got[26:11], want[26:11]);
    endtask
endclass

module tb;
    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic        cfg_data = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [31:0] m_tdata;

    mutex_scoreboard sb = new();
    int  hold_off = 0;     // long receiver stall, counted down in cycles
    bit  rx_enable = 0;

    always #1 aclk = ~aclk;

    recursive_mutex_with_wait_queue_unit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // receiver: checks accepted items and stalls on its own pattern
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_status(m_tdata);
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_tready <= 0;
        end else if (!rx_enable) begin
            m_tready <= 0;
        end else begin
            // stretches of full speed, mixed with random stalls
            m_tready <= ($urandom_range(0, 99) < 70) || ($urandom_range(0, 7) == 0);
        end
    end

    // offer one request item and wait for acceptance
    task automatic send_request(logic [1:0] kind, rmwq_pkg::id_t id);
        s_tvalid <= 1;
        s_tdata  <= {id, kind};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(kind, id);
    endtask

    task automatic idle_sender(int n);
        s_tvalid <= 0;
        repeat (n) @(posedge aclk);
    endtask

    // wait until every expected item has come, plus the walk latency
    task automatic drain();
        s_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (2 * rmwq_pkg::MAX_WAITERS + 8) @(posedge aclk);
    endtask

    task automatic write_recursive(bit value);
        cfg_valid <= 1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 0;
        sb.recursive = value;
    endtask

    // random id from a small pool so owners and waiters collide often
    function automatic rmwq_pkg::id_t pick_id();
        if ($urandom_range(0, 9) == 0) return rmwq_pkg::id_t'($urandom);
        return rmwq_pkg::id_t'($urandom_range(0, 19) ^
                               ($urandom_range(0, 1) ? 6'h2a : 6'h00));
    endfunction

    task automatic random_phase(int count);
        int sent, burst;
        logic [1:0] kind;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && sent < count) begin
                // weight towards lock and unlock so the queue fills and drains
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: kind = rmwq_pkg::KIND_LOCK;
                    4:          kind = rmwq_pkg::KIND_TRYLOCK;
                    5, 6, 7:    kind = rmwq_pkg::KIND_UNLOCK;
                    default:    kind = rmwq_pkg::KIND_CANCEL;
                endcase
                if (kind == rmwq_pkg::KIND_UNLOCK && sb.owned && $urandom_range(0, 1))
                    send_request(kind, sb.owner);
                else if (kind == rmwq_pkg::KIND_CANCEL && sb.waiters.size() != 0
                         && $urandom_range(0, 2) != 0)
                    send_request(kind, sb.waiters[$urandom_range(0, sb.waiters.size() - 1)]);
                else if (kind != rmwq_pkg::KIND_UNLOCK && sb.owned
                         && $urandom_range(0, 3) == 0)
                    send_request(kind, sb.owner);
                else
                    send_request(kind, pick_id());
                sent++;
                burst--;
            end
            if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 12));
        end
    endtask

    initial begin
        int i;
        sb.clear();
        repeat (7) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        rx_enable = 1;

        // directed: non-recursive mode
        send_request(rmwq_pkg::KIND_UNLOCK, 6'd0);     // unlock while free
        send_request(rmwq_pkg::KIND_CANCEL, 6'd63);    // cancel of absent requester
        send_request(rmwq_pkg::KIND_LOCK, 6'd63);      // acquire
        send_request(rmwq_pkg::KIND_LOCK, 6'd63);      // non-recursive relock
        send_request(rmwq_pkg::KIND_TRYLOCK, 6'd63);   // trylock by owner: busy
        send_request(rmwq_pkg::KIND_TRYLOCK, 6'd0);    // busy
        for (i = 0; i < rmwq_pkg::MAX_WAITERS; i++)
            send_request(rmwq_pkg::KIND_LOCK, rmwq_pkg::id_t'(i));  // fill the queue
        send_request(rmwq_pkg::KIND_LOCK, 6'd40);      // full queue
        send_request(rmwq_pkg::KIND_CANCEL, 6'd5);     // cancel from the middle
        send_request(rmwq_pkg::KIND_LOCK, 6'd3);       // already waiting
        send_request(rmwq_pkg::KIND_UNLOCK, 6'd21);    // unlock by non-owner hands over
        drain();

        // recursive mode: nesting, then clear it while nested
        write_recursive(1);
        send_request(rmwq_pkg::KIND_LOCK, sb.owner);
        send_request(rmwq_pkg::KIND_TRYLOCK, sb.owner);
        drain();
        write_recursive(0);
        send_request(rmwq_pkg::KIND_UNLOCK, sb.owner); // counts down normally
        drain();

        // deeper nesting by lock and trylock
        write_recursive(1);
        for (i = 0; i < 40; i++) begin
            send_request($urandom_range(0, 1) ? rmwq_pkg::KIND_LOCK
                                              : rmwq_pkg::KIND_TRYLOCK, sb.owner);
            if ($urandom_range(0, 7) == 0) idle_sender($urandom_range(1, 4));
        end
        // receiver holds off while the sender keeps offering items
        hold_off = 300;
        for (i = 0; i < 20; i++) send_request(rmwq_pkg::KIND_UNLOCK, sb.owner);
        drain();                                  // sender pauses until all in

        // bring the counter back down without checking each by hand
        while (sb.depth > 1) send_request(rmwq_pkg::KIND_UNLOCK, sb.owner);
        drain();

        random_phase(600);
        drain();
        write_recursive(0);
        random_phase(600);
        drain();
        write_recursive(1);
        hold_off = 200;
        random_phase(700);
        drain();

        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #3000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
